// ===== hw/rtl/dmnf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmnf_pkg
// Shared types and codes of the depth mask neighbourhood filter: channel
// payloads, configuration register map, operation codes and pipeline tags.
// ----------------------------------------------------------------------------
package dmnf_pkg;

    // configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_CONNECTED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIFFERENCE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 3'd5;

    // operation codes
    localparam logic [1:0] OP_ERODE      = 2'd0;
    localparam logic [1:0] OP_MIN_COUNT  = 2'd1;
    localparam logic [1:0] OP_LOCAL_DIFF = 2'd2;
    localparam logic [1:0] OP_PASS       = 2'd3;

    // field widths
    localparam int DEPTH_W  = 16;
    localparam int POS_W    = 10;
    localparam int GEOM_W   = 11;
    localparam int MINCNT_W = 4;
    localparam int LIMIT_W  = 20;
    localparam int CNT_W    = 4;

    // geometry limits and reset values
    localparam logic [GEOM_W-1:0] FRAME_MIN      = 11'd3;
    localparam logic [GEOM_W-1:0] FRAME_H_MAX    = 11'd1024;
    localparam logic [GEOM_W-1:0] WIDTH_DEFAULT  = 11'd640;
    localparam logic [GEOM_W-1:0] HEIGHT_DEFAULT = 11'd576;

    // neighbour counts of the two connectivities
    localparam logic [CNT_W-1:0] NB_FOUR  = 4'd4;
    localparam logic [CNT_W-1:0] NB_EIGHT = 4'd8;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_value;
        logic               mask_in;
    } pixel_t;

    typedef struct packed {
        logic [POS_W-1:0] pixel_row;
        logic [POS_W-1:0] pixel_column;
        logic             mask_out;
    } result_t;

    typedef struct packed {
        logic [1:0]          operation;
        logic                eight_connected;
        logic [MINCNT_W-1:0] min_neighbour_count;
        logic [LIMIT_W-1:0]  max_mean_difference;
        logic [GEOM_W-1:0]   frame_width;
        logic [GEOM_W-1:0]   frame_height;
    } cfg_t;

    // what travels with one pixel through the pipeline
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic             has_interior;
        logic             has_border;
        logic             border_mask;
    } tag_t;

    // one queue entry holds all results caused by one pixel
    typedef struct packed {
        tag_t tag;
        logic interior_mask;
    } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dmnf_line_buf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmnf_line_buf
// Two line stores holding the previous two rows of depth and valid bits.
// Read on the accepting cycle, written back in the cycle after.
// ----------------------------------------------------------------------------
module dmnf_line_buf #(
    parameter int MAX_WIDTH  = 1024,
    parameter int DEPTH_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [DEPTH_BITS:0]          wr_cell,
    output logic [DEPTH_BITS:0]          rd_upper,
    output logic [DEPTH_BITS:0]          rd_middle
);
    import dmnf_pkg::*;

    logic [DEPTH_BITS:0] upper_mem  [MAX_WIDTH];
    logic [DEPTH_BITS:0] middle_mem [MAX_WIDTH];
    logic [DEPTH_BITS:0] rd_upper_reg;
    logic [DEPTH_BITS:0] rd_middle_reg;

    // registered read of both rows at the current column
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg  <= upper_mem[rd_addr];
            rd_middle_reg <= middle_mem[rd_addr];
        end
    end

    // rows move up: middle goes to upper, new pixel goes to middle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= rd_middle_reg;
            middle_mem[wr_addr] <= wr_cell;
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dmnf_judge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmnf_judge
// 3x3 window register and the decision for the centre pixel: neighbor
// differences and count in one stage, sum and threshold test in the next.
// ----------------------------------------------------------------------------
module dmnf_judge #(
    parameter int DEPTH_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dmnf_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    input  logic [DEPTH_BITS:0]   rd_upper,
    input  logic [DEPTH_BITS:0]   rd_middle,
    input  logic [DEPTH_BITS:0]   new_cell,
    input  dmnf_pkg::tag_t        tag,
    output logic                  push,
    output dmnf_pkg::entry_t      entry,
    output logic [1:0]            busy
);
    import dmnf_pkg::*;

    localparam int SUM_W    = DEPTH_BITS + 4;
    localparam int SCALED_W = SUM_W + 4;
    localparam int PROD_W   = LIMIT_W + CNT_W;
    localparam int TEST_W   = (SCALED_W > PROD_W) ? SCALED_W : PROD_W;

    logic [DEPTH_BITS:0]   win_reg  [9];
    logic [DEPTH_BITS:0]   win_next [9];
    logic                  v2_reg;
    tag_t                  tag2_reg;

    logic [DEPTH_BITS-1:0] diff_reg  [9];
    logic [DEPTH_BITS-1:0] diff_next [9];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic                  cv_reg;
    logic                  v3_reg;
    tag_t                  tag3_reg;

    logic [SUM_W-1:0]      sum;
    logic [TEST_W-1:0]     scaled;
    logic [TEST_W-1:0]     prod;
    logic [CNT_W-1:0]      nb_total;
    logic                  interior_mask;

    // shift the window one column and take in the new column
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3+1];
            win_next[i*3+1]   = win_reg[i*3+2];
        end
        win_next[2] = rd_upper;
        win_next[5] = rd_middle;
        win_next[8] = new_cell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            if (in_valid)
            begin
                for (int i = 0; i < 9; i++)
                begin
                    win_reg[i] <= win_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag2_reg <= tag;
    end

    // absolute differences of the valid neighbors and their count;
    // corners only take part with eight neighbors
    always_comb
    begin
        logic [DEPTH_BITS-1:0] cd;
        logic [DEPTH_BITS-1:0] d;
        logic                  use_nb;
        cd       = win_reg[4][DEPTH_BITS-1:0];
        cnt_next = '0;
        for (int k = 0; k < 9; k++)
        begin
            d      = win_reg[k][DEPTH_BITS-1:0];
            use_nb = (k != 4) && win_reg[k][DEPTH_BITS]
                     && (cfg.eight_connected || (k % 2 == 1));
            if (!use_nb)
            begin
                diff_next[k] = '0;
            end
            else if (d >= cd)
            begin
                diff_next[k] = d - cd;
            end
            else
            begin
                diff_next[k] = cd - d;
            end
            cnt_next = cnt_next + CNT_W'(use_nb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            diff_reg[k] <= diff_next[k];
        end
        cnt_reg  <= cnt_next;
        cv_reg   <= win_reg[4][DEPTH_BITS];
        tag3_reg <= tag2_reg;
    end

    // sum of differences and the mean test 16*sum < limit*count
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 9; k++)
        begin
            sum = sum + SUM_W'(diff_reg[k]);
        end
        scaled   = TEST_W'({sum, 4'b0000});
        prod     = TEST_W'(cfg.max_mean_difference) * TEST_W'(cnt_reg);
        nb_total = cfg.eight_connected ? NB_EIGHT : NB_FOUR;
    end

    // new valid bit of the centre pixel
    always_comb
    begin
        case (cfg.operation)
            OP_PASS:       interior_mask = cv_reg;
            OP_ERODE:      interior_mask = cv_reg && (cnt_reg == nb_total);
            OP_MIN_COUNT:  interior_mask = cv_reg && (cnt_reg >= cfg.min_neighbour_count);
            OP_LOCAL_DIFF: interior_mask = cv_reg && (cnt_reg != '0) && (scaled < prod);
            default:       interior_mask = 1'b0;
        endcase
    end

    assign push                = v3_reg && (tag3_reg.has_interior || tag3_reg.has_border);
    assign entry.tag           = tag3_reg;
    assign entry.interior_mask = interior_mask;
    assign busy                = 2'(v2_reg) + 2'(v3_reg);

endmodule
`default_nettype wire

// ===== hw/rtl/dmnf_res_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dmnf_res_fifo
// Result queue. One entry per pixel carries up to two results; the delayed
// interior result leaves first, then the border result of the same pixel.
// ----------------------------------------------------------------------------
module dmnf_res_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  dmnf_pkg::entry_t            entry,
    output logic                        result_valid,
    input  logic                        result_stall,
    output dmnf_pkg::result_t           result,
    output logic [dmnf_pkg::FIFO_PTR_W:0] count
);
    import dmnf_pkg::*;

    entry_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W:0]   count_reg;
    logic                  half_reg;

    entry_t                head;
    logic                  take;
    logic                  show_interior;
    logic                  last;
    logic                  pop;

    // head of queue and which of its results is shown
    assign head          = mem_reg[rd_ptr_reg];
    assign result_valid  = (count_reg != '0);
    assign take          = result_valid && !result_stall;
    assign show_interior = head.tag.has_interior && !half_reg;
    assign last          = !(head.tag.has_interior && head.tag.has_border) || half_reg;
    assign pop           = take && last;
    assign count         = count_reg;

    always_comb
    begin
        if (show_interior)
        begin
            result.pixel_row    = head.tag.row - POS_W'(1);
            result.pixel_column = head.tag.column - POS_W'(1);
            result.mask_out     = head.interior_mask;
        end
        else
        begin
            result.pixel_row    = head.tag.row;
            result.pixel_column = head.tag.column;
            result.mask_out     = head.tag.border_mask;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    // pointers, fill count and half select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_reg + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
            if (take)
            begin
                half_reg <= !last;
            end
        end
    end

    // queue never overfills
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("result queue count above depth");

    // credit scheme at the input keeps room for every entry
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg < (FIFO_PTR_W+1)'(FIFO_DEPTH))
        else $error("push into full result queue");

    // second half only exists for an entry that carries two results
    a_half_pair: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg |-> (count_reg != '0) && head.tag.has_interior && head.tag.has_border)
        else $error("half select set on a single-result entry");

endmodule
`default_nettype wire

// ===== hw/rtl/depth_mask_neighbourhood_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depth_mask_neighbourhood_filter
// One 3x3 neighborhood pass (erosion, minimum neighbors, local depth
// difference or plain pass) over a raster stream of depth pixels with valid bits.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless stalled; a pixel that causes two
// results offers them in turn; the 8-entry result queue then back-pressures.
// Pipeline: a pixel passes the line store read, the window, the differences
// and then enters the result queue, from which its result is offered.
// Reset: configuration to defaults, position counters and window cleared,
// queue empty; the line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module depth_mask_neighbourhood_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int DEPTH_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    output logic                               pixel_stall,
    input  dmnf_pkg::pixel_t                   pixel,
    output logic                               result_valid,
    input  logic                               result_stall,
    output dmnf_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dmnf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dmnf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dmnf_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (COL_W + 1 > GEOM_W) ? COL_W + 1 : GEOM_W;
    localparam int CELL_W = DEPTH_BITS + 1;
    localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);

    cfg_t                cfg_reg;
    logic [POS_W-1:0]    row_reg;
    logic [POS_W-1:0]    row_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;

    logic [CMP_W-1:0]    fw_ext;
    logic [CMP_W-1:0]    w;
    logic [GEOM_W-1:0]   h_clamp;
    logic [CMP_W-1:0]    h;
    logic [CMP_W-1:0]    rr;
    logic [CMP_W-1:0]    cc;
    logic [CMP_W-1:0]    row_inc;

    logic                accept;
    logic [CELL_W-1:0]   px_cell;
    tag_t                tag;

    logic                s1_valid_reg;
    logic [CELL_W-1:0]   s1_cell_reg;
    logic [COL_W-1:0]    s1_addr_reg;
    tag_t                s1_tag_reg;

    logic [CELL_W-1:0]   rd_upper;
    logic [CELL_W-1:0]   rd_middle;
    logic                push;
    entry_t              entry;
    logic [1:0]          judge_busy;
    logic [FIFO_PTR_W:0] fifo_count;
    logic [FIFO_PTR_W+2:0] credit;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.operation           <= OP_ERODE;
            cfg_reg.eight_connected     <= 1'b0;
            cfg_reg.min_neighbour_count <= '0;
            cfg_reg.max_mean_difference <= '0;
            cfg_reg.frame_width         <= WIDTH_DEFAULT;
            cfg_reg.frame_height        <= HEIGHT_DEFAULT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OPERATION:       cfg_reg.operation <= cfg_data[1:0];
                CFG_EIGHT_CONNECTED: cfg_reg.eight_connected <= cfg_data[0];
                CFG_MIN_COUNT:       cfg_reg.min_neighbour_count <= cfg_data[MINCNT_W-1:0];
                CFG_MAX_DIFFERENCE:  cfg_reg.max_mean_difference <= cfg_data[LIMIT_W-1:0];
                CFG_FRAME_WIDTH:     cfg_reg.frame_width <= cfg_data[GEOM_W-1:0];
                CFG_FRAME_HEIGHT:    cfg_reg.frame_height <= cfg_data[GEOM_W-1:0];
                default:             ;
            endcase
        end
    end

    // frame geometry saturated to its legal range
    always_comb
    begin
        fw_ext = CMP_W'(cfg_reg.frame_width);
        if (fw_ext < CMP_W'(FRAME_MIN))
        begin
            w = CMP_W'(FRAME_MIN);
        end
        else if (fw_ext > MAX_W_C)
        begin
            w = MAX_W_C;
        end
        else
        begin
            w = fw_ext;
        end
        if (cfg_reg.frame_height < FRAME_MIN)
        begin
            h_clamp = FRAME_MIN;
        end
        else if (cfg_reg.frame_height > FRAME_H_MAX)
        begin
            h_clamp = FRAME_H_MAX;
        end
        else
        begin
            h_clamp = cfg_reg.frame_height;
        end
        h = CMP_W'(h_clamp);
    end

    // position of the arriving pixel and what it causes
    assign rr      = CMP_W'(row_reg);
    assign cc      = CMP_W'(col_reg);
    assign accept  = pixel_valid && !pixel_stall;
    assign px_cell = {pixel.mask_in, pixel.depth_value[DEPTH_BITS-1:0]};

    always_comb
    begin
        tag.row          = row_reg;
        tag.column       = cc[POS_W-1:0];
        tag.has_interior = (rr >= CMP_W'(2)) && (cc >= CMP_W'(2)) && (rr < h) && (cc < w);
        tag.has_border   = (row_reg == '0) || (col_reg == '0)
                           || (rr >= h - CMP_W'(1)) || (cc >= w - CMP_W'(1));
        tag.border_mask  = ((cfg_reg.operation == OP_MIN_COUNT)
                            || (cfg_reg.operation == OP_PASS)) && pixel.mask_in;
    end

    // raster counters, wrapping at the current frame size
    always_comb
    begin
        row_inc = rr + CMP_W'(1);
        if (cc + CMP_W'(1) >= w)
        begin
            col_next = '0;
            row_next = (row_inc >= h) ? '0 : row_inc[POS_W-1:0];
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    // payload of the line store stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cell_reg <= px_cell;
            s1_addr_reg <= col_reg;
            s1_tag_reg  <= tag;
        end
    end

    // input stalls unless the queue has room for everything in flight
    assign credit = (FIFO_PTR_W+3)'(fifo_count) + (FIFO_PTR_W+3)'(s1_valid_reg)
                    + (FIFO_PTR_W+3)'(judge_busy) + (FIFO_PTR_W+3)'(1);
    assign pixel_stall = credit > (FIFO_PTR_W+3)'(FIFO_DEPTH);

    dmnf_line_buf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_line_buf (
        .clk       (clk),
        .rd_en     (accept),
        .rd_addr   (col_reg),
        .wr_en     (s1_valid_reg),
        .wr_addr   (s1_addr_reg),
        .wr_cell   (s1_cell_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    dmnf_judge #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s1_valid_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle),
        .new_cell  (s1_cell_reg),
        .tag       (s1_tag_reg),
        .push      (push),
        .entry     (entry),
        .busy      (judge_busy)
    );

    dmnf_res_fifo u_res_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .entry        (entry),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .count        (fifo_count)
    );

endmodule
`default_nettype wire
